/* rtl/ils_pkg.sv */
package ils_pkg;

  localparam int DEPTH = 16;
  localparam int DW    = 32;
  localparam int PW    = 5;
  localparam int NW    = 5;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = (CW > PW) ? CW : PW;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [2:0] {
    FN_GET       = 3'd0,
    FN_APPEND    = 3'd1,
    FN_PREPEND   = 3'd2,
    FN_INSERT    = 3'd3,
    FN_DEL_LAST  = 3'd4,
    FN_DEL_FIRST = 3'd5,
    FN_DEL_AT    = 3'd6,
    FN_SIZE      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t      mode;
    logic [XW-1:0]   pos;
    logic [XW-1:0]   rd_pos;
    word_t           value;
  } cell_ctrl_t;

endpackage

/* rtl/indexed_list_store.sv */
// A word's result is registered onto the response port in the cycle after it is accepted.
// Throughput: 1 word per cycle unless rsp_stall holds; every operation takes at most one shift.
// The response register frees the request side whenever it is empty or being taken.
// Reset (rst, synchronous, active high) empties the list and clears the response valid.
// Stored entries are not cleared; only entries below the count are ever read.
module indexed_list_store import ils_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [2:0]           func,
  input  logic [PW-1:0]        position,
  input  logic signed [DW-1:0] item_value,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic signed [DW-1:0] read_value,
  output logic [NW-1:0]        entry_count,
  output logic [1:0]           status
);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  word_t         read_value_next;
  status_t       status_next;
  cell_ctrl_t    ctrl;
  logic          take;
  logic          full;
  logic          empty;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] count_x;
  word_t         cell_q   [DEPTH];
  word_t         rd_chain [DEPTH+1];

  assign req_stall = rsp_valid & rsp_stall;
  assign take      = req_valid & ~req_stall;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_x     = XW'(position);
  assign count_x   = XW'(count);

  always_comb begin
    ctrl.mode       = CELL_HOLD;
    ctrl.pos        = '0;
    ctrl.rd_pos     = pos_x;
    ctrl.value      = item_value;
    count_next      = count;
    read_value_next = '0;
    status_next     = ST_OK;
    case (func_t'(func))
      FN_GET: begin
        if (pos_x < count_x) begin
          read_value_next = rd_chain[DEPTH];
        end else begin
          read_value_next = '1;
          status_next     = ST_RANGE;
        end
      end
      FN_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.mode  = CELL_INS;
          ctrl.pos   = count_x;
          count_next = count + 1'b1;
        end
      end
      FN_PREPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.mode  = CELL_INS;
          count_next = count + 1'b1;
        end
      end
      FN_INSERT: begin
        if (pos_x > count_x) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.mode  = CELL_INS;
          ctrl.pos   = pos_x;
          count_next = count + 1'b1;
        end
      end
      FN_DEL_LAST: begin
        if (empty) begin
          status_next = ST_RANGE;
        end else begin
          count_next = count - 1'b1;
        end
      end
      FN_DEL_FIRST: begin
        if (empty) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.mode  = CELL_DEL;
          count_next = count - 1'b1;
        end
      end
      FN_DEL_AT: begin
        if (pos_x >= count_x) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.mode  = CELL_DEL;
          ctrl.pos   = pos_x;
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!take) begin
      ctrl.mode  = CELL_HOLD;
      count_next = count;
    end
  end

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_d;
    word_t right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .idx        (XW'(i)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_in      (rd_chain[i]),
      .data       (cell_q[i]),
      .rd_out     (rd_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (take) begin
      read_value  <= read_value_next;
      entry_count <= NW'(count_next);
      status      <= status_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    take && func == FN_APPEND && !full |=> count == $past(count) + 1'b1)
    else $error("append did not grow list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == NW'(DEPTH))
    else $error("full status with list not full");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid && entry_count == NW'(count))
    else $error("response missing after accept");

endmodule

/* rtl/ils_cell.sv */
module ils_cell import ils_pkg::*; (
  input  logic          clk,
  input  logic [XW-1:0] idx,
  input  cell_ctrl_t    ctrl,
  input  word_t         left_data,
  input  word_t         right_data,
  input  word_t         rd_in,
  output word_t         data,
  output word_t         rd_out
);

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CELL_INS: begin
        if (idx == ctrl.pos) begin
          data <= ctrl.value;
        end else if (idx > ctrl.pos) begin
          data <= left_data;
        end
      end
      CELL_DEL: begin
        if (idx >= ctrl.pos) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  // read word travels down the row; only the addressed cell contributes
  assign rd_out = rd_in | ((ctrl.rd_pos == idx) ? data : word_t'(0));

endmodule
